// File: rtl/core/blitter_word_datapath_unit_assert.svh
// Assertion macros for the blitter word datapath checker.
`ifndef BLITTER_WORD_DATAPATH_UNIT_ASSERT_SVH
`define BLITTER_WORD_DATAPATH_UNIT_ASSERT_SVH

// Same-cycle implication, held off while reset is high
`define BWD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blitter word datapath: same-cycle check failed");

// Next-cycle implication, held off while reset is high
`define BWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blitter word datapath: next-cycle check failed");

`endif

// File: rtl/core/bwd_pkg.sv
// Shared widths, register indexes, fill codes and types of the blitter word datapath.
package bwd_pkg;

  localparam int WORD_W      = 16;
  localparam int SHIFT_W     = 4;
  localparam int MINTERM_W   = 8;
  localparam int CFG_INDEX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MINTERM       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_A_SHIFT       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_B_SHIFT       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_MASK    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_MASK     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL_MODE     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DESCENDING    = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_FILL_CARRY_IN = 3'd7;

  // Fill modes: any mode with the exclusive bit set fills exclusively,
  // the remaining non-zero mode fills inclusively
  localparam logic [1:0] FILL_NONE = 2'd0;
  localparam logic [1:0] FILL_EXCL = 2'd2;

  localparam logic [WORD_W-1:0] WORD_ONES = {WORD_W{1'b1}};

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [MINTERM_W-1:0] minterm;
    logic [SHIFT_W-1:0]   a_shift;
    logic [SHIFT_W-1:0]   b_shift;
    word_t                first_mask;
    word_t                last_mask;
    logic [1:0]           fill_mode;
    logic                 descending;
    logic                 fill_carry_in;
  } bwd_cfg_t;

  typedef struct packed {
    word_t a_word;
    word_t b_word;
    word_t c_word;
    logic  row_first;
    logic  row_last;
    logic  blit_first;
  } bwd_item_t;

  // Fill control handed to the combine stage
  typedef struct packed {
    logic [1:0] mode;
    logic       carry;
  } bwd_fill_ctl_t;

endpackage

// File: rtl/core/bwd_if.sv
// Valid/ready channels carrying source words in and destination words out.
interface bwd_in_if;
  import bwd_pkg::*;

  logic  valid;
  logic  ready;
  word_t a_word;
  word_t b_word;
  word_t c_word;
  logic  row_first;
  logic  row_last;
  logic  blit_first;

  modport source (
    output valid, a_word, b_word, c_word, row_first, row_last, blit_first,
    input  ready
  );
  modport sink (
    input  valid, a_word, b_word, c_word, row_first, row_last, blit_first,
    output ready
  );
endinterface

interface bwd_out_if;
  import bwd_pkg::*;

  logic  valid;
  logic  ready;
  word_t d_word;
  logic  all_zero;

  modport source (output valid, d_word, all_zero, input ready);
  modport sink (input valid, d_word, all_zero, output ready);
endinterface

// File: rtl/core/bwd_barrel.sv
// Barrel shifter joining a channel's previous and current word.
module bwd_barrel (
  input  bwd_pkg::word_t                prev,
  input  bwd_pkg::word_t                cur,
  input  logic [bwd_pkg::SHIFT_W-1:0]   shift,
  input  logic                          left,
  output bwd_pkg::word_t                result
);
  import bwd_pkg::*;

  logic [2*WORD_W-1:0] asc_joined;
  logic [2*WORD_W-1:0] desc_joined;

  // Right shift takes the low half of {prev, cur}; left shift takes the high
  // half of {cur, prev}, so the top bits of prev enter from below and a zero
  // shift leaves the current word
  always_comb begin
    asc_joined  = {prev, cur} >> shift;
    desc_joined = {cur, prev} << shift;
    result      = left ? desc_joined[2*WORD_W-1:WORD_W] : asc_joined[WORD_W-1:0];
  end

endmodule

// File: rtl/core/bwd_combine.sv
// Minterm truth table over A, B, C followed by optional inclusive or exclusive area fill.
module bwd_combine (
  input  bwd_pkg::word_t                   a,
  input  bwd_pkg::word_t                   b,
  input  bwd_pkg::word_t                   c,
  input  logic [bwd_pkg::MINTERM_W-1:0]    minterm,
  input  bwd_pkg::bwd_fill_ctl_t           fill,
  output bwd_pkg::word_t                   d,
  output logic                             carry_out
);
  import bwd_pkg::*;

  word_t raw;
  word_t parity;
  word_t filled;
  logic  excl;

  // Look up each bit position in the truth table
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      raw[i] = minterm[{a[i], b[i], c[i]}];
    end
  end

  // Carry after bit i is the incoming carry xor the parity of bits 0..i
  always_comb begin
    excl = (fill.mode & FILL_EXCL) != FILL_NONE;
    for (int i = 0; i < WORD_W; i++) begin
      parity[i] = fill.carry ^ (^(raw & (WORD_ONES >> (WORD_W - 1 - i))));
      filled[i] = excl ? parity[i] : ((parity[i] ^ raw[i]) | raw[i]);
    end
  end

  // Pass through when fill is off, keeping the carry
  always_comb begin
    if (fill.mode == FILL_NONE) begin
      d         = raw;
      carry_out = fill.carry;
    end else begin
      d         = filled;
      carry_out = parity[WORD_W-1];
    end
  end

endmodule

// File: rtl/core/blitter_word_datapath_unit.sv
// Blitter word datapath: takes one word set (A, B, C and row/blit flags) per clock
// while dst.ready holds and returns the destination word and a sticky all-zero flag.
// A word is registered at acceptance, passes masking, both barrel shifts, the minterm
// table and the area fill combinationally, and lands in the result register when that
// register is free or being emptied, which raises dst.valid. The previous-word history
// and the fill carry are updated together with the result register, so consecutive
// words chain without a bubble.
// Configuration writes are taken at any time but must only be issued while no word
// is in flight.
module blitter_word_datapath_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [bwd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  bwd_pkg::word_t                    cfg_data,
  bwd_in_if.sink                            src,
  bwd_out_if.source                         dst
);
  import bwd_pkg::*;

  bwd_cfg_t      cfg;
  bwd_item_t     item;
  logic          in_valid;
  logic          out_valid;
  word_t         out_d;
  logic          out_zero;

  word_t         a_previous;
  word_t         b_previous;
  logic          row_fill_carry;
  logic          any_nonzero;

  logic          advance;
  word_t         a_masked;
  word_t         a_prev_eff;
  word_t         b_prev_eff;
  word_t         a_shifted;
  word_t         b_shifted;
  bwd_fill_ctl_t fill;
  word_t         d_next;
  logic          carry_next;
  logic          any_nonzero_next;

  // Move the held word on when the result register is free or being emptied
  assign advance   = in_valid && (!out_valid || dst.ready);
  assign src.ready = !in_valid || advance;

  assign dst.valid    = out_valid;
  assign dst.d_word   = out_d;
  assign dst.all_zero = out_zero;

  // Mask A at the row edges, drop history at the start of a blit and pick the fill carry
  always_comb begin
    a_masked = item.a_word;
    if (item.row_first) begin
      a_masked = a_masked & cfg.first_mask;
    end
    if (item.row_last) begin
      a_masked = a_masked & cfg.last_mask;
    end
    a_prev_eff = item.blit_first ? '0 : a_previous;
    b_prev_eff = item.blit_first ? '0 : b_previous;
    fill.mode  = cfg.fill_mode;
    fill.carry = item.row_first ? cfg.fill_carry_in : row_fill_carry;
  end

  bwd_barrel u_a_barrel (
    .prev   (a_prev_eff),
    .cur    (a_masked),
    .shift  (cfg.a_shift),
    .left   (cfg.descending),
    .result (a_shifted)
  );

  bwd_barrel u_b_barrel (
    .prev   (b_prev_eff),
    .cur    (item.b_word),
    .shift  (cfg.b_shift),
    .left   (cfg.descending),
    .result (b_shifted)
  );

  bwd_combine u_combine (
    .a         (a_shifted),
    .b         (b_shifted),
    .c         (item.c_word),
    .minterm   (cfg.minterm),
    .fill      (fill),
    .d         (d_next),
    .carry_out (carry_next)
  );

  // Track whether any word of this blit was nonzero
  assign any_nonzero_next = (any_nonzero && !item.blit_first) || (d_next != '0);

  // Control, configuration and channel history
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid           <= 1'b0;
      out_valid          <= 1'b0;
      a_previous         <= '0;
      b_previous         <= '0;
      row_fill_carry     <= 1'b0;
      any_nonzero        <= 1'b0;
      cfg.minterm        <= '0;
      cfg.a_shift        <= '0;
      cfg.b_shift        <= '0;
      cfg.first_mask     <= WORD_ONES;
      cfg.last_mask      <= WORD_ONES;
      cfg.fill_mode      <= FILL_NONE;
      cfg.descending     <= 1'b0;
      cfg.fill_carry_in  <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MINTERM:       cfg.minterm       <= cfg_data[MINTERM_W-1:0];
          REG_A_SHIFT:       cfg.a_shift       <= cfg_data[SHIFT_W-1:0];
          REG_B_SHIFT:       cfg.b_shift       <= cfg_data[SHIFT_W-1:0];
          REG_FIRST_MASK:    cfg.first_mask    <= cfg_data;
          REG_LAST_MASK:     cfg.last_mask     <= cfg_data;
          REG_FILL_MODE:     cfg.fill_mode     <= cfg_data[1:0];
          REG_DESCENDING:    cfg.descending    <= cfg_data[0];
          REG_FILL_CARRY_IN: cfg.fill_carry_in <= cfg_data[0];
        endcase
      end
      if (src.ready) begin
        in_valid <= src.valid;
      end
      if (advance) begin
        out_valid      <= 1'b1;
        a_previous     <= a_masked;
        b_previous     <= item.b_word;
        row_fill_carry <= carry_next;
        any_nonzero    <= any_nonzero_next;
      end else if (dst.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the accepted word and the finished result
  always_ff @(posedge clk) begin
    if (src.valid && src.ready) begin
      item.a_word     <= src.a_word;
      item.b_word     <= src.b_word;
      item.c_word     <= src.c_word;
      item.row_first  <= src.row_first;
      item.row_last   <= src.row_last;
      item.blit_first <= src.blit_first;
    end
    if (advance) begin
      out_d    <= d_next;
      out_zero <= !any_nonzero_next;
    end
  end

endmodule

// File: rtl/core/bwd_checker.sv
// Port-level checks on the blitter word datapath, bound to the top level.
`include "blitter_word_datapath_unit_assert.svh"

module bwd_checker (
  input logic           clk,
  input logic           rst,
  input logic           src_valid,
  input logic           src_ready,
  input logic           dst_valid,
  input logic           dst_ready,
  input bwd_pkg::word_t dst_d_word,
  input logic           dst_all_zero
);
  import bwd_pkg::*;

  // Input stalls only when both stages are full and the output is blocked
  `BWD_ASSERT_IMP(a_stall_only_when_full, clk, rst, !src_ready, dst_valid && !dst_ready)

  // An accepted word shows up at the output once it has passed the held-word and result registers
  `BWD_ASSERT_NEXT(a_word_reaches_output, clk, rst, src_valid && src_ready, ##1 dst_valid)

  // Nothing at the output straight after reset
  `BWD_ASSERT_NEXT(a_empty_after_reset, clk, 1'b0, rst, !dst_valid && src_ready)

  // A blocked result holds still
  `BWD_ASSERT_NEXT(a_result_held, clk, rst, dst_valid && !dst_ready, dst_valid && $stable(dst_d_word) && $stable(dst_all_zero))

endmodule

bind blitter_word_datapath_unit bwd_checker u_bwd_checker (
  .clk          (clk),
  .rst          (rst),
  .src_valid    (src.valid),
  .src_ready    (src.ready),
  .dst_valid    (dst.valid),
  .dst_ready    (dst.ready),
  .dst_d_word   (dst.d_word),
  .dst_all_zero (dst.all_zero)
);
